[rtl/assert_macros.svh]
// Assertion macros for the RTL files; only the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define AST_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define AST_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ifscg_pkg.sv]
// Shared types and constants of the chaos game plotter.
`default_nettype none
package ifscg_pkg;
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_PLOT  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_NFUNC  = 2'd2;

    localparam int NUM_SLOTS  = 6;
    localparam int CW         = 18;   // coefficient, Q2.16
    localparam int PW         = 24;   // point, Q8.16
    localparam int RNDW       = 16;
    localparam int DEF_WIDTH  = 640;
    localparam int DEF_HEIGHT = 480;
    localparam logic [3:0] SAT_LEVEL = 4'd15;

    typedef enum logic [2:0] {
        K_LOAD, K_LOAD_BAD, K_CLEAR, K_PLOT, K_SKIP, K_READ, K_READ_BAD
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [3:0]             fn;
        logic [2:0]             slot;
        logic signed [CW-1:0]   value;
        logic [RNDW-1:0]        rnd;
        logic [9:0]             rx;
        logic [9:0]             ry;
    } t_entry;

    typedef enum logic [3:0] {
        B_IDLE, B_CLEAR, B_MOD, B_CRD, B_MUL, B_SUM, B_MAP, B_CHK, B_RMW, B_READ
    } t_bstate;
endpackage
`default_nettype wire

[rtl/ifscg_ram.sv]
// Generic single-write, single-read RAM with registered read.
`default_nettype none
module ifscg_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[rtl/ifscg_front.sv]
// Front end: accepts input beats and classifies them into queue entries.
`default_nettype none
module ifscg_front #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int MAX_FUNCTIONS = 16
) (
    input  wire logic                 i_valid,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [3:0]           i_fn,
    input  wire logic [2:0]           i_slot,
    input  wire logic signed [17:0]   i_value,
    input  wire logic [15:0]          i_rnd,
    input  wire logic [9:0]           i_rx,
    input  wire logic [9:0]           i_ry,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     i_w,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]    i_h,
    input  wire logic [$clog2(MAX_FUNCTIONS+1)-1:0] i_nf,
    input  wire logic                 i_full,
    input  wire logic                 i_init_busy,
    output logic                      o_ready,
    output logic                      o_push,
    output ifscg_pkg::t_entry         o_entry
);
    import ifscg_pkg::*;

    logic load_ok;
    logic read_ok;

    assign load_ok = (32'(i_slot) < NUM_SLOTS) && (32'(i_fn) < MAX_FUNCTIONS);
    assign read_ok = (32'(i_rx) < 32'(i_w)) && (32'(i_ry) < 32'(i_h));

    assign o_ready = !i_full && !i_init_busy;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_entry.fn    = i_fn;
        o_entry.slot  = i_slot;
        o_entry.value = i_value;
        o_entry.rnd   = i_rnd;
        o_entry.rx    = i_rx;
        o_entry.ry    = i_ry;
        unique case (i_cmd)
            CMD_LOAD:  o_entry.kind = load_ok ? K_LOAD : K_LOAD_BAD;
            CMD_CLEAR: o_entry.kind = K_CLEAR;
            CMD_PLOT:  o_entry.kind = (i_nf == '0) ? K_SKIP : K_PLOT;
            CMD_READ:  o_entry.kind = read_ok ? K_READ : K_READ_BAD;
            default:   o_entry.kind = K_LOAD_BAD;
        endcase
    end
endmodule
`default_nettype wire

[rtl/ifscg_fifo.sv]
// Two-entry queue between front end and back end.
`default_nettype none
module ifscg_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ifscg_pkg::t_entry i_entry,
    input  wire logic              i_pop,
    output ifscg_pkg::t_entry      o_entry,
    output logic                   o_valid,
    output logic                   o_full
);
    import ifscg_pkg::*;

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
endmodule
`default_nettype wire

[rtl/ifscg_back.sv]
// Back end: coefficient table, point update, density store and result register.
`default_nettype none
module ifscg_back #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int MAX_FUNCTIONS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire ifscg_pkg::t_entry i_entry,
    output logic                   o_pop,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     i_w,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]    i_h,
    input  wire logic [$clog2(MAX_FUNCTIONS+1)-1:0] i_nf,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic               o_plotted,
    output logic [9:0]         o_px,
    output logic [9:0]         o_py,
    output logic [23:0]        o_color,
    output logic               o_init_busy
);
    import ifscg_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int HW    = $clog2(MAX_HEIGHT+1);
    localparam int NW    = $clog2(MAX_FUNCTIONS+1);
    localparam int FW    = (MAX_FUNCTIONS > 1) ? $clog2(MAX_FUNCTIONS) : 1;
    localparam int DDEP  = MAX_WIDTH * MAX_HEIGHT;
    localparam int DAW   = $clog2(DDEP);
    localparam int PRW   = CW + PW;
    localparam int SW    = PRW + 2;
    localparam int TW    = PW + 1;
    localparam int MXW   = PW + WW;
    localparam int MYW   = PW + HW;
    localparam int QXW   = MXW - 17;
    localparam int QYW   = MYW - 17;
    localparam logic [4:0] MOD_LAST = 5'(RNDW - 1);
    localparam logic signed [SW-1:0] Q_MAX = {{(SW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [SW-1:0] Q_MIN = {{(SW-PW+1){1'b1}}, {(PW-1){1'b0}}};

    function automatic logic signed [PW-1:0] sat_pt(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] q;
        q = s >>> 16;
        if (q > Q_MAX) begin
            q = Q_MAX;
        end else if (q < Q_MIN) begin
            q = Q_MIN;
        end
        return q[PW-1:0];
    endfunction

    t_bstate r_state, n_state;
    logic    r_init, n_init;
    logic [DAW-1:0] r_clr, n_clr;
    logic signed [PW-1:0] r_px, n_px, r_py, n_py;
    logic [RNDW-1:0] r_rnd, n_rnd;
    logic [NW-1:0]   r_rem, n_rem;
    logic [4:0]      r_cnt, n_cnt;
    logic signed [PRW-1:0] r_pax, n_pax, r_pby, n_pby, r_pcx, n_pcx, r_pdy, n_pdy;
    logic [MXW-1:0]  r_prx, n_prx;
    logic [MYW-1:0]  r_pry, n_pry;
    logic            r_tx_ok, n_tx_ok, r_ty_ok, n_ty_ok;
    logic [DAW-1:0]  r_daddr, n_daddr;
    logic [9:0]      r_qx, n_qx, r_qy, n_qy;
    logic            r_ov, n_ov;
    logic [1:0]      r_status, n_status;
    logic            r_plotted, n_plotted;
    logic [9:0]      r_ox, n_ox, r_oy, n_oy;
    logic [23:0]     r_color, n_color;

    logic            out_free;
    logic [NW:0]     rem_sh;
    logic signed [SW-1:0] s_x, s_y;
    logic signed [TW-1:0] t_x, t_y;
    logic [QXW-1:0]  pos_x;
    logic [QYW-1:0]  pos_y;
    logic            in_x, in_y;
    logic [7:0]      gray;
    logic [3:0]      cnt_inc;

    // coefficient table, one RAM per slot
    logic            coef_we;
    logic [CW-1:0]   coef_rd [NUM_SLOTS];
    logic signed [CW-1:0] c_a, c_b, c_c, c_d, c_e, c_f;

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_coef
        ifscg_ram #(
            .WIDTH (CW),
            .DEPTH (MAX_FUNCTIONS),
            .ADDR_W(FW)
        ) u_coef (
            .i_clk  (i_clk),
            .i_we   (coef_we && (i_entry.slot == 3'(i))),
            .i_waddr(FW'(i_entry.fn)),
            .i_wdata(i_entry.value),
            .i_raddr(r_rem[FW-1:0]),
            .o_rdata(coef_rd[i])
        );
    end

    assign c_a = $signed(coef_rd[0]);
    assign c_b = $signed(coef_rd[1]);
    assign c_c = $signed(coef_rd[2]);
    assign c_d = $signed(coef_rd[3]);
    assign c_e = $signed(coef_rd[4]);
    assign c_f = $signed(coef_rd[5]);

    // density store
    logic           d_we;
    logic [DAW-1:0] d_waddr, d_raddr;
    logic [3:0]     d_wdata, d_rdata;

    ifscg_ram #(
        .WIDTH (4),
        .DEPTH (DDEP),
        .ADDR_W(DAW)
    ) u_dens (
        .i_clk  (i_clk),
        .i_we   (d_we),
        .i_waddr(d_waddr),
        .i_wdata(d_wdata),
        .i_raddr(d_raddr),
        .o_rdata(d_rdata)
    );

    assign out_free = !r_ov || i_out_ready;
    assign rem_sh   = {r_rem, r_rnd[RNDW-1]};
    assign s_x = SW'(r_pax) + SW'(r_pby) + (SW'(c_e) <<< 16);
    assign s_y = SW'(r_pcx) + SW'(r_pdy) + (SW'(c_f) <<< 16);
    assign t_x = TW'(r_px) + TW'(32'sd65536);
    assign t_y = TW'(r_py) + TW'(32'sd65536);
    assign pos_x = r_prx[MXW-1:17];
    assign pos_y = r_pry[MYW-1:17];
    assign in_x  = r_tx_ok && (pos_x != '0) && (pos_x < QXW'(i_w));
    assign in_y  = r_ty_ok && (pos_y != '0) && (pos_y < QYW'(i_h));
    assign gray  = {d_rdata, 4'b0000};
    assign cnt_inc = (d_rdata < SAT_LEVEL) ? d_rdata + 4'd1 : d_rdata;

    always_comb begin
        n_state = r_state;   n_init = r_init;   n_clr = r_clr;
        n_px = r_px;         n_py = r_py;       n_rnd = r_rnd;
        n_rem = r_rem;       n_cnt = r_cnt;
        n_pax = r_pax;       n_pby = r_pby;     n_pcx = r_pcx;   n_pdy = r_pdy;
        n_prx = r_prx;       n_pry = r_pry;     n_tx_ok = r_tx_ok; n_ty_ok = r_ty_ok;
        n_daddr = r_daddr;   n_qx = r_qx;       n_qy = r_qy;
        n_ov = r_ov && !i_out_ready;
        n_status = r_status; n_plotted = r_plotted;
        n_ox = r_ox;         n_oy = r_oy;       n_color = r_color;
        o_pop   = 1'b0;
        coef_we = 1'b0;
        d_we    = 1'b0;
        d_waddr = r_clr;
        d_wdata = 4'd0;
        d_raddr = r_daddr;

        unique case (r_state)
            B_IDLE: begin
                if (i_valid && out_free) begin
                    o_pop     = 1'b1;
                    n_ov      = 1'b1;
                    n_status  = ST_DONE;
                    n_plotted = 1'b0;
                    n_ox      = 10'd0;
                    n_oy      = 10'd0;
                    n_color   = 24'd0;
                    case (i_entry.kind)
                        K_LOAD: begin
                            coef_we = 1'b1;
                        end
                        K_CLEAR: begin
                            n_px    = '0;
                            n_py    = '0;
                            n_clr   = '0;
                            n_state = B_CLEAR;
                        end
                        K_PLOT: begin
                            n_ov    = 1'b0;
                            n_rnd   = i_entry.rnd;
                            n_rem   = '0;
                            n_cnt   = 5'd0;
                            n_state = B_MOD;
                        end
                        K_SKIP: begin
                            n_status = ST_SKIP;
                        end
                        K_READ: begin
                            n_ov    = 1'b0;
                            d_raddr = DAW'(i_entry.ry) * DAW'(MAX_WIDTH) + DAW'(i_entry.rx);
                            n_state = B_READ;
                        end
                        default: begin
                            n_status = ST_BAD;
                        end
                    endcase
                end
            end
            B_CLEAR: begin
                d_we  = 1'b1;
                n_clr = r_clr + DAW'(1);
                if (r_clr == DAW'(DDEP - 1)) begin
                    n_init  = 1'b0;
                    n_state = B_IDLE;
                end
            end
            B_MOD: begin
                // restoring remainder, one bit of the random word per cycle
                if (rem_sh >= (NW+1)'(i_nf)) begin
                    n_rem = NW'(rem_sh - (NW+1)'(i_nf));
                end else begin
                    n_rem = rem_sh[NW-1:0];
                end
                n_rnd = r_rnd << 1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == MOD_LAST) begin
                    n_state = B_CRD;
                end
            end
            B_CRD: begin
                n_state = B_MUL;
            end
            B_MUL: begin
                n_pax   = PRW'(c_a) * PRW'(r_px);
                n_pby   = PRW'(c_b) * PRW'(r_py);
                n_pcx   = PRW'(c_c) * PRW'(r_px);
                n_pdy   = PRW'(c_d) * PRW'(r_py);
                n_state = B_SUM;
            end
            B_SUM: begin
                n_px    = sat_pt(s_x);
                n_py    = sat_pt(s_y);
                n_state = B_MAP;
            end
            B_MAP: begin
                n_tx_ok = (t_x > TW'(0));
                n_ty_ok = (t_y > TW'(0));
                n_prx   = MXW'(t_x[PW-1:0]) * MXW'(i_w);
                n_pry   = MYW'(t_y[PW-1:0]) * MYW'(i_h);
                n_state = B_CHK;
            end
            B_CHK: begin
                n_qx    = pos_x[9:0];
                n_qy    = pos_y[9:0];
                n_daddr = DAW'(pos_y) * DAW'(MAX_WIDTH) + DAW'(pos_x);
                d_raddr = n_daddr;
                if (in_x && in_y) begin
                    n_state = B_RMW;
                end else begin
                    n_ov      = 1'b1;
                    n_status  = ST_DONE;
                    n_plotted = 1'b0;
                    n_ox      = 10'd0;
                    n_oy      = 10'd0;
                    n_color   = 24'd0;
                    n_state   = B_IDLE;
                end
            end
            B_RMW: begin
                d_we      = 1'b1;
                d_waddr   = r_daddr;
                d_wdata   = cnt_inc;
                n_ov      = 1'b1;
                n_status  = ST_DONE;
                n_plotted = 1'b1;
                n_ox      = r_qx;
                n_oy      = r_qy;
                n_color   = 24'd0;
                n_state   = B_IDLE;
            end
            B_READ: begin
                n_ov      = 1'b1;
                n_status  = ST_DONE;
                n_plotted = 1'b0;
                n_ox      = 10'd0;
                n_oy      = 10'd0;
                n_color   = {gray, gray, gray};
                n_state   = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_init  <= 1'b1;
            r_clr   <= '0;
            r_px    <= '0;
            r_py    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_clr   <= n_clr;
            r_px    <= n_px;
            r_py    <= n_py;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd     <= n_rnd;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_pax     <= n_pax;
        r_pby     <= n_pby;
        r_pcx     <= n_pcx;
        r_pdy     <= n_pdy;
        r_prx     <= n_prx;
        r_pry     <= n_pry;
        r_tx_ok   <= n_tx_ok;
        r_ty_ok   <= n_ty_ok;
        r_daddr   <= n_daddr;
        r_qx      <= n_qx;
        r_qy      <= n_qy;
        r_status  <= n_status;
        r_plotted <= n_plotted;
        r_ox      <= n_ox;
        r_oy      <= n_oy;
        r_color   <= n_color;
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_status;
    assign o_plotted   = r_plotted;
    assign o_px        = r_ox;
    assign o_py        = r_oy;
    assign o_color     = r_color;
    assign o_init_busy = r_init;
endmodule
`default_nettype wire

[rtl/ifs_chaos_game_plotter_top.sv]
// Load, skip and rejected items answer from idle; a read passes the density read state; a
// plot runs a bit-serial remainder that picks the map, then coefficient read, multiply, sum,
// map, check and, inside the frame, the density update. The back end runs one item at a
// time; a clear beat returns at once but sweeps the whole density store before the next item.
// Reset (synchronous, active low): point to origin, registers to 640x480 and no maps, then
// a sweep of all MAX_WIDTH*MAX_HEIGHT cells zeroes the density store while s_tready stays low.
`default_nettype none
module ifs_chaos_game_plotter_top #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int MAX_FUNCTIONS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] coef_function, [6:4] coef_slot, [24:7] coef_value, [40:25] random_word,
    // [50:41] read_x, [60:51] read_y
    input  wire logic [63:0] s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] plotted, [10:1] plot_x, [20:11] plot_y, [44:21] pixel_color
    output logic [47:0]      m_tdata,
    // [1:0] status
    output logic [1:0]       m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ifscg_pkg::*;
    `include "assert_macros.svh"

    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int HW    = $clog2(MAX_HEIGHT+1);
    localparam int NW    = $clog2(MAX_FUNCTIONS+1);
    localparam int DEF_W = (DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH;
    localparam int DEF_H = (DEF_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : DEF_HEIGHT;

    logic [10:0] r_fw, r_fh;
    logic [4:0]  r_nf;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 11'(DEF_WIDTH);
            r_fh <= 11'(DEF_HEIGHT);
            r_nf <= 5'd0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WIDTH:  r_fw <= pwdata[10:0];
                REG_HEIGHT: r_fh <= pwdata[10:0];
                REG_NFUNC:  r_nf <= pwdata[4:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = 32'(r_fw);
            REG_HEIGHT: prdata = 32'(r_fh);
            REG_NFUNC:  prdata = 32'(r_nf);
            default:    prdata = 32'd0;
        endcase
    end

    // effective frame size and map count
    logic [WW-1:0] w_sat, w_eff;
    logic [HW-1:0] h_sat, h_eff;
    logic [NW-1:0] nf_eff;

    assign w_sat  = (32'(r_fw) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(r_fw);
    assign h_sat  = (32'(r_fh) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_fh);
    assign w_eff  = (w_sat == '0 || h_sat == '0) ? WW'(DEF_W) : w_sat;
    assign h_eff  = (w_sat == '0 || h_sat == '0) ? HW'(DEF_H) : h_sat;
    assign nf_eff = (32'(r_nf) > MAX_FUNCTIONS) ? NW'(MAX_FUNCTIONS) : NW'(r_nf);

    t_entry f_entry, q_entry;
    logic   f_push, q_full, q_valid, q_pop, init_busy;
    logic   out_plotted;
    logic [9:0]  out_px, out_py;
    logic [23:0] out_color;

    ifscg_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_FUNCTIONS(MAX_FUNCTIONS)
    ) u_front (
        .i_valid    (s_tvalid),
        .i_cmd      (s_tuser),
        .i_fn       (s_tdata[3:0]),
        .i_slot     (s_tdata[6:4]),
        .i_value    ($signed(s_tdata[24:7])),
        .i_rnd      (s_tdata[40:25]),
        .i_rx       (s_tdata[50:41]),
        .i_ry       (s_tdata[60:51]),
        .i_w        (w_eff),
        .i_h        (h_eff),
        .i_nf       (nf_eff),
        .i_full     (q_full),
        .i_init_busy(init_busy),
        .o_ready    (s_tready),
        .o_push     (f_push),
        .o_entry    (f_entry)
    );

    ifscg_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_push),
        .i_entry(f_entry),
        .i_pop  (q_pop),
        .o_entry(q_entry),
        .o_valid(q_valid),
        .o_full (q_full)
    );

    ifscg_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_FUNCTIONS(MAX_FUNCTIONS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_entry    (q_entry),
        .o_pop      (q_pop),
        .i_w        (w_eff),
        .i_h        (h_eff),
        .i_nf       (nf_eff),
        .i_out_ready(m_tready),
        .o_out_valid(m_tvalid),
        .o_status   (m_tuser),
        .o_plotted  (out_plotted),
        .o_px       (out_px),
        .o_py       (out_py),
        .o_color    (out_color),
        .o_init_busy(init_busy)
    );

    assign m_tdata = {3'b000, out_color, out_py, out_px, out_plotted};

    `AST_ALWAYS(a_rst_sweep, i_clk, !i_rst_n |=> !s_tready, "no sweep after reset")
    `AST_ON(a_plot_ok, i_clk, i_rst_n, m_tvalid && out_plotted |-> m_tuser == ST_DONE,
        "plotted dot with bad status")
    `AST_ON(a_bad_dark, i_clk, i_rst_n, m_tvalid && m_tuser != ST_DONE |-> out_color == 24'd0,
        "color on failed item")
    `AST_ON(a_pop_data, i_clk, i_rst_n, q_pop |-> q_valid, "pop from empty queue")
endmodule
`default_nettype wire
